@@ hdl/srtf_pkg.sv @@
// Shared types and constants of the SRTF tick scheduler.
package srtf_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] ready_at;
		logic [15:0] run_len;
	} req_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic        ran_valid;
		logic        finished;
		logic [31:0] finished_wait;
		logic [31:0] tick_time;
		logic        all_done;
		logic        rejected;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_UPD_INIT,
		ST_UPD,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic walk_start;
		logic walk_en;
		logic upd_mode;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} status_t;

endpackage

@@ hdl/srtf_ctrl.sv @@
// Control state machine of the SRTF tick scheduler.
module srtf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_func,
	input  srtf_pkg::status_t status,
	output srtf_pkg::cmd_t   cmd,
	output logic             req_stall
);
	import srtf_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nx = (req_func == FUNC_TICK) ? ST_SCAN_INIT : ST_COMMIT;
				end
			end
			ST_SCAN_INIT: state_nx = ST_SCAN;
			ST_SCAN: begin
				if (status.walk_done) begin
					state_nx = ST_UPD_INIT;
				end
			end
			ST_UPD_INIT: state_nx = ST_UPD;
			ST_UPD: begin
				if (status.walk_done) begin
					state_nx = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			ST_SCAN_INIT: cmd.walk_start = 1'b1;
			ST_SCAN:      cmd.walk_en    = 1'b1;
			ST_UPD_INIT:  cmd.walk_start = 1'b1;
			ST_UPD: begin
				cmd.walk_en  = 1'b1;
				cmd.upd_mode = 1'b1;
			end
			ST_COMMIT:    cmd.commit = status.out_free;
			default:      cmd = '0;
		endcase
	end

endmodule

@@ hdl/srtf_dp.sv @@
// Datapath of the SRTF tick scheduler: task table, walk, selection, result register.
module srtf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  srtf_pkg::req_t    req,
	input  srtf_pkg::cmd_t    cmd,
	output srtf_pkg::status_t status,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output srtf_pkg::rsp_t    rsp
);
	import srtf_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

	logic [31:0] arr_mem  [MAX_TASKS];
	logic [15:0] rem_mem  [MAX_TASKS];
	logic [31:0] wait_mem [MAX_TASKS];

	req_t             req_q;
	logic [CNT_W-1:0] loaded_q, live_q, rd_cnt_q;
	logic [31:0]      time_q;
	logic             rdv_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      arr_s1, wait_s1;
	logic [15:0]      rem_s1;
	logic             found_q, fin_q;
	logic [IDX_W-1:0] best_q;
	logic [15:0]      best_rem_q;
	logic [31:0]      fwait_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             elig, is_best, full, issue, out_free;
	logic             arr_we, rem_we, wait_we;
	logic [IDX_W-1:0] wr_idx, rd_idx;
	logic [15:0]      rem_wd;
	logic [31:0]      wait_wd;
	logic [CNT_W-1:0] live_nx;
	rsp_t             res;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign full     = (loaded_q == MAX_CNT);
	assign issue    = cmd.walk_en && (rd_cnt_q != loaded_q);
	assign rd_idx   = rd_cnt_q[IDX_W-1:0];
	assign elig     = (rem_s1 != 16'd0) && (arr_s1 <= time_q);
	assign is_best  = found_q && (idx_s1 == best_q);

	assign status.walk_done = (rd_cnt_q == loaded_q) && !rdv_s1;
	assign status.out_free  = out_free;

	always_comb begin
		arr_we  = 1'b0;
		rem_we  = 1'b0;
		wait_we = 1'b0;
		wr_idx  = idx_s1;
		rem_wd  = rem_s1 - 16'd1;
		wait_wd = wait_s1 + 32'd1;
		if (cmd.commit && req_q.func == FUNC_LOAD && !full) begin
			arr_we  = 1'b1;
			rem_we  = 1'b1;
			wait_we = 1'b1;
			wr_idx  = loaded_q[IDX_W-1:0];
			rem_wd  = req_q.run_len;
			wait_wd = 32'd0;
		end else if (cmd.upd_mode && rdv_s1) begin
			if (is_best) begin
				rem_we = 1'b1;
			end else if (elig && wait_s1 != 32'hFFFF_FFFF) begin
				wait_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arr_we) begin
			arr_mem[wr_idx] <= req_q.ready_at;
		end
		if (rem_we) begin
			rem_mem[wr_idx] <= rem_wd;
		end
		if (wait_we) begin
			wait_mem[wr_idx] <= wait_wd;
		end
		arr_s1  <= arr_mem[rd_idx];
		rem_s1  <= rem_mem[rd_idx];
		wait_s1 <= wait_mem[rd_idx];
		idx_s1  <= rd_idx;
	end

	always_comb begin
		res = '0;
		res.tick_time = time_q;
		if (req_q.func == FUNC_LOAD) begin
			live_nx = live_q;
			if (full) begin
				res.rejected = 1'b1;
			end else begin
				res.slot = 4'(loaded_q[IDX_W-1:0]);
				if (req_q.run_len != 16'd0) begin
					live_nx = live_q + CNT_W'(1);
				end
			end
		end else begin
			live_nx = live_q - CNT_W'(fin_q);
			if (found_q) begin
				res.slot          = 4'(best_q);
				res.ran_valid     = 1'b1;
				res.finished      = fin_q;
				res.finished_wait = fin_q ? fwait_q : 32'd0;
			end
		end
		res.all_done = (live_nx == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
		if (cmd.walk_en && rdv_s1 && !cmd.upd_mode && elig &&
		    (!found_q || rem_s1 < best_rem_q)) begin
			best_q     <= idx_s1;
			best_rem_q <= rem_s1;
		end
		if (cmd.upd_mode && rdv_s1 && is_best) begin
			fwait_q <= wait_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			live_q      <= '0;
			time_q      <= '0;
			rd_cnt_q    <= '0;
			rdv_s1      <= 1'b0;
			found_q     <= 1'b0;
			fin_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				rd_cnt_q <= '0;
				rdv_s1   <= 1'b0;
				if (!cmd.upd_mode && !found_q && !fin_q) begin
					found_q <= 1'b0;
				end
			end else if (cmd.walk_en) begin
				rdv_s1 <= issue;
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.capture) begin
				found_q <= 1'b0;
				fin_q   <= 1'b0;
			end else if (cmd.walk_en && rdv_s1 && !cmd.upd_mode && elig) begin
				found_q <= 1'b1;
			end
			if (cmd.upd_mode && rdv_s1 && is_best) begin
				fin_q <= (rem_s1 == 16'd1);
			end
			if (cmd.commit) begin
				live_q <= live_nx;
				if (req_q.func == FUNC_LOAD) begin
					if (!full) begin
						loaded_q <= loaded_q + CNT_W'(1);
					end
				end else begin
					time_q <= time_q + 32'd1;
				end
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_loaded_max: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= MAX_CNT) else $error("loaded count above table size");
	a_live_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= loaded_q) else $error("pending count above loaded count");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> (CNT_W'(idx_s1) < loaded_q)) else $error("walk read past loaded slots");
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (CNT_W'(best_q) < loaded_q)) else $error("chosen slot not loaded");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_free) else $error("result overwritten while held");

endmodule

@@ hdl/srtf_tick_scheduler.sv @@
// Top level of the shortest-remaining-time-first tick scheduler.
// Request channel: req_valid / req_stall with payload req. func selects a
// load (store arrival and burst in the next free slot) or a tick (run the
// eligible task with least remaining time, lowest slot on ties, add one
// waiting tick to every other eligible task, then advance time).
// Response channel: rsp_valid / rsp_stall with payload rsp, one response per
// request, in order.
// Sequencing: a load goes from idle straight to the commit step, which
// registers the response. A tick walks the loaded slots twice through the
// single read port of the task table, once to pick the task and once to
// update it and the waiting counts; each walk reads every loaded slot and
// then drains the read pipeline before the next step. The block returns to
// idle as the response is set and takes the next request from idle.
// One request is worked at a time; req_stall is low only while idle, and a
// new request is taken while the previous response still waits.
// A stalled response holds in the output register; the block then stops in
// its final step until that register frees up.
// Reset clears the slot count, pending count, time and all handshake state;
// no clearing pass is needed, table entries are used only once loaded.
module srtf_tick_scheduler (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  srtf_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output srtf_pkg::rsp_t  rsp
);
	import srtf_pkg::*;

	cmd_t    cmd;
	status_t status;

	srtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.status    (status),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	srtf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
